// ===== rtl/akp_pkg.sv =====
// Shared types, constants and tables for the accelerometer tilt block.
package akp_pkg;

    localparam int RAW_BITS_DEF = 16;
    localparam int GAIN_W       = 25;
    localparam int ACC_W        = 32;
    localparam int TEMP_W       = 40;
    localparam int ANG_W        = 25;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 3;

    localparam int CORDIC_STEPS = 22;
    localparam int CW           = 36;
    localparam int ZW           = 26;
    localparam int SQRT_STAGES  = 32;

    localparam int SCALE_LAT    = 2;
    localparam int HYP_LAT      = 2 + SQRT_STAGES;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int LATENCY      = SCALE_LAT + HYP_LAT + CORDIC_LAT;

    localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ZW-1:0] DEG90  = 26'sd5898240;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
        26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115,
        26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_X       = 3'd0,
        REG_GAIN_Y       = 3'd1,
        REG_GAIN_Z       = 3'd2,
        REG_TEMP_GAIN    = 3'd3,
        REG_TEMP_OFFSET  = 3'd4,
        REG_TEMP_PRESENT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic        [GAIN_W-1:0] gain_x;
        logic        [GAIN_W-1:0] gain_y;
        logic        [GAIN_W-1:0] gain_z;
        logic signed [31:0]       temp_gain;
        logic signed [31:0]       temp_offset;
        logic                     temp_present;
    } cfg_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]  ax;
        logic signed [ACC_W-1:0]  ay;
        logic signed [ACC_W-1:0]  az;
        logic signed [TEMP_W-1:0] temp;
    } axes_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 fixed;
    } cordic_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] q;
        logic [63:0] n;
    } sqrt_t;

endpackage

// ===== rtl/akp_scale.sv =====
// Axis gain scaling and temperature conversion, two register stages.
module akp_scale #(
    parameter int RAW_BITS = akp_pkg::RAW_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [RAW_BITS-1:0] raw_x,
    input  logic signed [RAW_BITS-1:0] raw_y,
    input  logic signed [RAW_BITS-1:0] raw_z,
    input  logic signed [RAW_BITS-1:0] raw_t,
    input  akp_pkg::cfg_t              cfg,
    output logic                       out_valid,
    output akp_pkg::axes_t             out
);

    localparam int PA = RAW_BITS + akp_pkg::GAIN_W + 1;
    localparam int PT = RAW_BITS + 32;
    localparam int PD = PT + 1;

    logic signed [PA-1:0] px_reg, py_reg, pz_reg;
    logic signed [PT-1:0] pt_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    akp_pkg::axes_t       out_reg;
    akp_pkg::axes_t       out_next;
    logic signed [PD-1:0] tdiff;
    logic signed [71:0]   twide;

    function automatic logic signed [akp_pkg::ACC_W-1:0] round_sat(
        input logic signed [PA-1:0] p
    );
        logic signed [PA-1:0] r;
        logic signed [63:0]   w;
        r = (p + PA'(128)) >>> 8;
        w = 64'(r);
        if (w > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (w < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return w[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= PA'(raw_x) * PA'($signed({1'b0, cfg.gain_x}));
        py_reg  <= PA'(raw_y) * PA'($signed({1'b0, cfg.gain_y}));
        pz_reg  <= PA'(raw_z) * PA'($signed({1'b0, cfg.gain_z}));
        pt_reg  <= PT'(raw_t) * PT'(cfg.temp_gain);
        out_reg <= out_next;
    end

    always_comb
    begin
        tdiff       = PD'(pt_reg) - PD'(cfg.temp_offset);
        twide       = 72'(tdiff);
        out_next.ax = round_sat(px_reg);
        out_next.ay = round_sat(py_reg);
        out_next.az = round_sat(pz_reg);
        if (!cfg.temp_present)
            out_next.temp = '0;
        else if (twide > 72'sh00_7F_FFFF_FFFF)
            out_next.temp = 40'sh7F_FFFF_FFFF;
        else if (twide < -72'sh00_80_0000_0000)
            out_next.temp = 40'sh80_0000_0000;
        else
            out_next.temp = twide[akp_pkg::TEMP_W-1:0];
    end

    assign out_valid = v2_reg;
    assign out       = out_reg;

endmodule

// ===== rtl/akp_hyp.sv =====
// Horizontal magnitude: squares, sum and a pipelined integer square root.
module akp_hyp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [akp_pkg::ACC_W-1:0] ay,
    input  logic signed [akp_pkg::ACC_W-1:0] az,
    output logic                             out_valid,
    output logic        [31:0]               horiz
);

    localparam int NS = akp_pkg::SQRT_STAGES;

    logic signed [63:0] sqy_reg, sqz_reg;
    logic        [63:0] sum_reg;
    logic               va_reg, vb_reg;
    logic               vs_reg [NS];
    akp_pkg::sqrt_t     st_reg [NS];
    akp_pkg::sqrt_t     st_in  [NS];
    akp_pkg::sqrt_t     st_nx  [NS];

    always_ff @(posedge clk)
    begin
        sqy_reg <= 64'(ay) * 64'(ay);
        sqz_reg <= 64'(az) * 64'(az);
        sum_reg <= $unsigned(sqy_reg) + $unsigned(sqz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_sqrt
            logic [34:0] rem_s;
            logic [34:0] trial;

            if (k == 0)
            begin : g_first
                assign st_in[k] = '{rem: '0, q: '0, n: sum_reg};
            end
            else
            begin : g_next
                assign st_in[k] = st_reg[k-1];
            end

            always_comb
            begin
                rem_s       = {st_in[k].rem, st_in[k].n[63:62]};
                trial       = {1'b0, st_in[k].q, 2'b01};
                st_nx[k].n  = {st_in[k].n[61:0], 2'b00};
                if (rem_s >= trial)
                begin
                    st_nx[k].rem = 33'(rem_s - trial);
                    st_nx[k].q   = {st_in[k].q[30:0], 1'b1};
                end
                else
                begin
                    st_nx[k].rem = rem_s[32:0];
                    st_nx[k].q   = {st_in[k].q[30:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                st_reg[k] <= st_nx[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vs_reg[k] <= 1'b0;
                else if (k == 0)
                    vs_reg[k] <= vb_reg;
                else
                    vs_reg[k] <= vs_reg[(k == 0) ? 0 : k-1];
            end
        end
    endgenerate

    assign out_valid = vs_reg[NS-1];
    assign horiz     = st_reg[NS-1].q;

endmodule

// ===== rtl/akp_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees.
module akp_cordic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [akp_pkg::ACC_W:0]   y_in,
    input  logic signed [akp_pkg::ACC_W:0]   x_in,
    output logic                             out_valid,
    output logic signed [akp_pkg::ANG_W-1:0] angle
);

    localparam int N  = akp_pkg::CORDIC_STEPS;
    localparam int CW = akp_pkg::CW;

    akp_pkg::cordic_t              st_reg [N+1];
    akp_pkg::cordic_t              st_nx  [N+1];
    logic                          v_reg  [N+1];
    logic                          vo_reg;
    logic signed [akp_pkg::ANG_W-1:0] angle_reg;
    logic signed [CW-1:0]          xe, ye;

    always_comb
    begin
        xe       = CW'(x_in);
        ye       = CW'(y_in);
        st_nx[0] = '{x: xe, y: ye, z: '0, fixed: 1'b0};
        if (ye == '0)
        begin
            st_nx[0].fixed = 1'b1;
            st_nx[0].z     = (xe >= 0) ? '0 : akp_pkg::DEG180;
        end
        else if (xe == '0)
        begin
            st_nx[0].fixed = 1'b1;
            st_nx[0].z     = (ye > 0) ? akp_pkg::DEG90 : -akp_pkg::DEG90;
        end
        else if (xe < 0)
        begin
            st_nx[0].z = (ye > 0) ? akp_pkg::DEG180 : -akp_pkg::DEG180;
            st_nx[0].x = -xe;
            st_nx[0].y = -ye;
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_iter
            always_comb
            begin
                st_nx[i+1] = st_reg[i];
                if (!st_reg[i].fixed)
                begin
                    if (st_reg[i].y > 0)
                    begin
                        st_nx[i+1].x = st_reg[i].x + (st_reg[i].y >>> i);
                        st_nx[i+1].y = st_reg[i].y - (st_reg[i].x >>> i);
                        st_nx[i+1].z = st_reg[i].z + akp_pkg::ATAN_TAB[i];
                    end
                    else
                    begin
                        st_nx[i+1].x = st_reg[i].x - (st_reg[i].y >>> i);
                        st_nx[i+1].y = st_reg[i].y + (st_reg[i].x >>> i);
                        st_nx[i+1].z = st_reg[i].z - akp_pkg::ATAN_TAB[i];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= N; s++)
            st_reg[s] <= st_nx[s];
        if (st_reg[N].z > akp_pkg::DEG180)
            angle_reg <= akp_pkg::ANG_W'(akp_pkg::DEG180);
        else if (st_reg[N].z < -akp_pkg::DEG180)
            angle_reg <= akp_pkg::ANG_W'(-akp_pkg::DEG180);
        else
            angle_reg <= st_reg[N].z[akp_pkg::ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= N; s++)
                v_reg[s] <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= N; s++)
                v_reg[s] <= v_reg[s-1];
            vo_reg <= v_reg[N];
        end
    end

    assign out_valid = vo_reg;
    assign angle     = angle_reg;

endmodule

// ===== rtl/accel_tilt_pitch_roll.sv =====
// Top level of the accelerometer tilt, pitch and roll block.
// One sample is taken in every clock cycle (busy is always low) and each
// result appears on the output ports flagged by done for one cycle; results
// cannot be held off. Each result passes through the 32-stage square root
// of ay^2+az^2 followed by the 22-step CORDIC pipeline, plus scaling,
// squaring and rounding stages. Configuration registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while no
// sample is in flight, which the block itself does not enforce.
module accel_tilt_pitch_roll #(
    parameter int RAW_BITS = akp_pkg::RAW_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [RAW_BITS-1:0]           raw_x,
    input  logic signed [RAW_BITS-1:0]           raw_y,
    input  logic signed [RAW_BITS-1:0]           raw_z,
    input  logic signed [RAW_BITS-1:0]           raw_temperature,
    input  logic                                 cfg_we,
    input  logic        [akp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [akp_pkg::CFG_W-1:0]     cfg_data,
    output logic                                 done,
    output logic signed [akp_pkg::ACC_W-1:0]     accel_x,
    output logic signed [akp_pkg::ACC_W-1:0]     accel_y,
    output logic signed [akp_pkg::ACC_W-1:0]     accel_z,
    output logic signed [akp_pkg::ANG_W-1:0]     pitch,
    output logic signed [akp_pkg::ANG_W-1:0]     roll,
    output logic signed [akp_pkg::TEMP_W-1:0]    temperature
);

    localparam int SQ_TAP = akp_pkg::HYP_LAT - 1;
    localparam int DLY    = akp_pkg::HYP_LAT + akp_pkg::CORDIC_LAT;

    akp_pkg::cfg_t  cfg_reg;
    akp_pkg::axes_t sc_out;
    logic           sc_valid;
    akp_pkg::axes_t dly_reg [DLY];
    logic           hyp_valid;
    logic [31:0]    horiz;
    logic           pitch_valid, roll_valid;
    akp_pkg::axes_t tap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (akp_pkg::cfg_idx_t'(cfg_index))
                akp_pkg::REG_GAIN_X:       cfg_reg.gain_x       <= cfg_data[24:0];
                akp_pkg::REG_GAIN_Y:       cfg_reg.gain_y       <= cfg_data[24:0];
                akp_pkg::REG_GAIN_Z:       cfg_reg.gain_z       <= cfg_data[24:0];
                akp_pkg::REG_TEMP_GAIN:    cfg_reg.temp_gain    <= $signed(cfg_data);
                akp_pkg::REG_TEMP_OFFSET:  cfg_reg.temp_offset  <= $signed(cfg_data);
                akp_pkg::REG_TEMP_PRESENT: cfg_reg.temp_present <= cfg_data[0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    akp_scale #(
        .RAW_BITS (RAW_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .raw_z     (raw_z),
        .raw_t     (raw_temperature),
        .cfg       (cfg_reg),
        .out_valid (sc_valid),
        .out       (sc_out)
    );

    always_ff @(posedge clk)
    begin
        dly_reg[0] <= sc_out;
        for (int k = 1; k < DLY; k++)
            dly_reg[k] <= dly_reg[k-1];
    end

    assign tap = dly_reg[SQ_TAP];

    akp_hyp u_hyp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sc_valid),
        .ay        (sc_out.ay),
        .az        (sc_out.az),
        .out_valid (hyp_valid),
        .horiz     (horiz)
    );

    akp_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hyp_valid),
        .y_in      (-(33'(tap.ax))),
        .x_in      ({1'b0, horiz}),
        .out_valid (pitch_valid),
        .angle     (pitch)
    );

    akp_cordic u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hyp_valid),
        .y_in      (33'(tap.ay)),
        .x_in      (33'(tap.az)),
        .out_valid (roll_valid),
        .angle     (roll)
    );

    assign busy        = 1'b0;
    assign done        = pitch_valid & roll_valid;
    assign accel_x     = dly_reg[DLY-1].ax;
    assign accel_y     = dly_reg[DLY-1].ay;
    assign accel_z     = dly_reg[DLY-1].az;
    assign temperature = dly_reg[DLY-1].temp;

endmodule

// ===== rtl/akp_checker.sv =====
// Port-level timing and range checks for the tilt block, bound to the top level.
module akp_checker #(
    parameter int RAW_BITS = akp_pkg::RAW_BITS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic signed [akp_pkg::ANG_W-1:0] pitch,
    input logic signed [akp_pkg::ANG_W-1:0] roll,
    input logic signed [RAW_BITS-1:0]       raw_x
);

    localparam int LAT = akp_pkg::LATENCY;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer accepted but no result after fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching input transfer");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch <= akp_pkg::DEG180 && pitch >= -akp_pkg::DEG180 &&
                  roll <= akp_pkg::DEG180 && roll >= -akp_pkg::DEG180))
        else $error("angle outside of +-180 degrees");

    a_pitch_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(start && !busy && raw_x == '0, LAT) |-> pitch == '0)
        else $error("pitch nonzero for zero x sample");

endmodule

bind accel_tilt_pitch_roll akp_checker #(
    .RAW_BITS (RAW_BITS)
) u_akp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .pitch (pitch),
    .roll  (roll),
    .raw_x (raw_x)
);
